// ===== rtl/awg_command_player_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the command player
// Clocked, reset-qualified implication checks used by awgcp_out.
// ----------------------------------------------------------------------------
`ifndef AWG_COMMAND_PLAYER_ASSERT_SVH
`define AWG_COMMAND_PLAYER_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold too.
`define AWGCP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("awgcp assertion failed");

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define AWGCP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("awgcp assertion failed");

`endif

// ===== rtl/awgcp_pkg.sv =====
// ----------------------------------------------------------------------------
// awgcp_pkg
// Widths, command codes, types and helpers of the command player.
// ----------------------------------------------------------------------------
package awgcp_pkg;

	localparam int WAVE_BITS  = 16;
	localparam int PTR_BITS   = 10;
	localparam int MEM_DEPTH  = 1 << PTR_BITS;
	localparam int DATA_BYTES = (WAVE_BITS + 7) / 8;
	localparam int ADDR_BYTES = (PTR_BITS + 7) / 8;
	localparam int MAX_BYTES  = (DATA_BYTES > ADDR_BYTES) ? DATA_BYTES : ADDR_BYTES;
	localparam int ASM_W      = 8 * MAX_BYTES;
	localparam int SAMPLE_W   = 16;
	localparam int BEATS      = 8;
	localparam int BEAT_W     = 3;

	localparam logic [31:0] WAVE_BITS_WORD = 32'(WAVE_BITS);
	localparam logic [31:0] PTR_BITS_WORD  = 32'(PTR_BITS);

	localparam logic [7:0] BYTE_RESET = 8'hEE;
	localparam logic [7:0] BYTE_ESC   = 8'h55;
	localparam logic [7:0] CMD_START  = 8'hF0;
	localparam logic [7:0] CMD_STOP   = 8'hF1;
	localparam logic [7:0] CMD_WIDTHS = 8'hF2;
	localparam logic [7:0] CMD_LOAD   = 8'hF3;
	localparam logic [7:0] CMD_LENGTH = 8'hF4;
	localparam logic [7:0] CMD_STATUS = 8'hF5;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_LENGTH,
		PH_LOAD
	} phase_t;

	typedef enum logic [1:0] {
		OP_SAMPLE,
		OP_STATUS,
		OP_WIDTHS
	} op_t;

	typedef struct packed {
		logic valid;
		op_t  op;
		logic status;
	} res_req_t;

	typedef struct packed {
		logic                 en;
		logic [PTR_BITS-1:0]  addr;
		logic [WAVE_BITS-1:0] data;
	} mem_wr_t;

	typedef struct packed {
		logic                en;
		logic [PTR_BITS-1:0] addr;
	} mem_rd_t;

	// Byte of the width reply: data width word first, then address width word,
	// each little-endian.
	function automatic logic [7:0] width_reply_byte(logic [BEAT_W-1:0] beat);
		logic [31:0] w;
		w = beat[2] ? PTR_BITS_WORD : WAVE_BITS_WORD;
		return w[{beat[1:0], 3'b000} +: 8];
	endfunction

endpackage

// ===== rtl/awgcp_cmd_if.sv =====
// ----------------------------------------------------------------------------
// awgcp_cmd_if
// Input channel: host bytes and sample ticks with valid/ready.
// ----------------------------------------------------------------------------
interface awgcp_cmd_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] byte_value;

	modport source (output valid, kind, byte_value, input ready);
	modport sink   (input valid, kind, byte_value, output ready);
endinterface

// ===== rtl/awgcp_res_if.sv =====
// ----------------------------------------------------------------------------
// awgcp_res_if
// Output channel: reply bytes and played samples with valid/ready.
// ----------------------------------------------------------------------------
interface awgcp_res_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [7:0]  reply_byte;
	logic signed [15:0] sample_out;
	logic        last;

	modport source (output valid, result_kind, reply_byte, sample_out, last, input ready);
	modport sink   (input valid, result_kind, reply_byte, sample_out, last, output ready);
endinterface

// ===== rtl/awg_command_player.sv =====
// ----------------------------------------------------------------------------
// awg_command_player
// Byte-command waveform player: parser, sample memory and result stage.
// ----------------------------------------------------------------------------
// Path: an accepted input item passes the memory read and result stage, then
//   the output register, before its result item appears on res.
// Throughput: one input item per cycle while res is not stalled; the width
//   reply drives eight output items and holds input until all are emitted.
// Reset: clears the parser, length, write and play pointers and the running
//   flag; sample memory has no reset and keeps whatever it held.
module awg_command_player (
	input  logic        clk,
	input  logic        arst_n,
	awgcp_cmd_if.sink   cmd,
	awgcp_res_if.source res
);

	logic                            accept;
	logic                            ready;
	awgcp_pkg::mem_wr_t              wr;
	awgcp_pkg::mem_rd_t              rd;
	awgcp_pkg::res_req_t             req;
	logic [awgcp_pkg::WAVE_BITS-1:0] rd_data;

	// Take an item whenever the result stage is free or frees up this cycle.
	assign cmd.ready = ready;
	assign accept    = cmd.valid && ready;

	// Decode bytes, advance the load and play pointers, issue memory accesses.
	awgcp_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.kind       (cmd.kind),
		.byte_value (cmd.byte_value),
		.wr         (wr),
		.rd         (rd),
		.req        (req)
	);

	// Writes land at the accepting edge, so a tick in the next cycle reads the
	// new sample: no forwarding path needed.
	awgcp_sample_mem u_mem (
		.clk       (clk),
		.wr        (wr),
		.rd        (rd),
		.rd_data_q (rd_data)
	);

	// Hold the pending result, expand multi-byte replies, drive the output.
	awgcp_out u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.req     (req),
		.rd_data (rd_data),
		.ready   (ready),
		.res     (res)
	);

endmodule

// ===== rtl/awgcp_sample_mem.sv =====
// ----------------------------------------------------------------------------
// awgcp_sample_mem
// Waveform sample store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module awgcp_sample_mem (
	input  logic                               clk,
	input  awgcp_pkg::mem_wr_t                 wr,
	input  awgcp_pkg::mem_rd_t                 rd,
	output logic [awgcp_pkg::WAVE_BITS-1:0]    rd_data_q
);

	logic [awgcp_pkg::WAVE_BITS-1:0] mem [awgcp_pkg::MEM_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		// hold read data until the next read so a stalled sample keeps its value
		if (rd.en) begin
			rd_data_q <= mem[rd.addr];
		end
	end

endmodule

// ===== rtl/awgcp_parser.sv =====
// ----------------------------------------------------------------------------
// awgcp_parser
// Byte parser, command decode, load/length assembly and playback pointer.
// ----------------------------------------------------------------------------
module awgcp_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic                 kind,
	input  logic [7:0]           byte_value,
	output awgcp_pkg::mem_wr_t   wr,
	output awgcp_pkg::mem_rd_t   rd,
	output awgcp_pkg::res_req_t  req
);

	localparam int AW = awgcp_pkg::PTR_BITS;
	localparam int DW = awgcp_pkg::WAVE_BITS;
	localparam int AS = awgcp_pkg::ASM_W;

	logic                esc_q, esc_d;
	awgcp_pkg::phase_t   phase_q, phase_d;
	logic [1:0]          bcnt_q, bcnt_d;
	logic [AS-1:0]       asm_q, asm_d, asm_shift;
	logic [AW-1:0]       len_q, len_d;
	logic [AW-1:0]       wa_q, wa_d;
	logic                running_q, running_d;
	logic [AW-1:0]       play_q, play_d;
	logic [2:0]          need;

	assign asm_shift = AS'({asm_q, byte_value});
	assign need = (phase_q == awgcp_pkg::PH_LENGTH) ? 3'(awgcp_pkg::ADDR_BYTES)
	                                                : 3'(awgcp_pkg::DATA_BYTES);

	always_comb begin
		esc_d     = esc_q;
		phase_d   = phase_q;
		bcnt_d    = bcnt_q;
		asm_d     = asm_q;
		len_d     = len_q;
		wa_d      = wa_q;
		running_d = running_q;
		play_d    = play_q;
		wr        = '0;
		rd        = '0;
		req       = '0;
		if (accept) begin
			if (kind) begin
				if (running_q) begin
					rd.en     = 1'b1;
					rd.addr   = play_q;
					req.valid = 1'b1;
					req.op    = awgcp_pkg::OP_SAMPLE;
					play_d    = (play_q == len_q) ? '0 : play_q + 1'b1;
				end
			end else if (!esc_q && byte_value == awgcp_pkg::BYTE_RESET) begin
				esc_d   = 1'b0;
				phase_d = awgcp_pkg::PH_IDLE;
				bcnt_d  = '0;
				asm_d   = '0;
			end else if (!esc_q && byte_value == awgcp_pkg::BYTE_ESC) begin
				esc_d = 1'b1;
			end else begin
				esc_d = 1'b0;
				case (phase_q)
					awgcp_pkg::PH_IDLE: begin
						case (byte_value)
							awgcp_pkg::CMD_START: begin
								running_d = 1'b1;
								play_d    = '0;
							end
							awgcp_pkg::CMD_STOP: begin
								running_d = 1'b0;
							end
							awgcp_pkg::CMD_WIDTHS: begin
								req.valid = 1'b1;
								req.op    = awgcp_pkg::OP_WIDTHS;
							end
							awgcp_pkg::CMD_LOAD: begin
								phase_d = awgcp_pkg::PH_LOAD;
								bcnt_d  = '0;
								asm_d   = '0;
								wa_d    = '0;
							end
							awgcp_pkg::CMD_LENGTH: begin
								phase_d = awgcp_pkg::PH_LENGTH;
								bcnt_d  = '0;
								asm_d   = '0;
							end
							awgcp_pkg::CMD_STATUS: begin
								req.valid  = 1'b1;
								req.op     = awgcp_pkg::OP_STATUS;
								req.status = running_q;
							end
							default: ;
						endcase
					end
					awgcp_pkg::PH_LENGTH, awgcp_pkg::PH_LOAD: begin
						if ({1'b0, bcnt_q} + 3'd1 < need) begin
							bcnt_d = bcnt_q + 2'd1;
							asm_d  = asm_shift;
						end else begin
							bcnt_d = '0;
							asm_d  = '0;
							if (phase_q == awgcp_pkg::PH_LENGTH) begin
								len_d   = asm_shift[AW-1:0];
								phase_d = awgcp_pkg::PH_IDLE;
							end else begin
								wr.en   = 1'b1;
								wr.addr = wa_q;
								wr.data = asm_shift[DW-1:0];
								if (wa_q == len_q) begin
									wa_d    = '0;
									phase_d = awgcp_pkg::PH_IDLE;
								end else begin
									wa_d = wa_q + 1'b1;
								end
							end
						end
					end
					default: begin
						phase_d = awgcp_pkg::PH_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q     <= 1'b0;
			phase_q   <= awgcp_pkg::PH_IDLE;
			bcnt_q    <= '0;
			asm_q     <= '0;
			len_q     <= '0;
			wa_q      <= '0;
			running_q <= 1'b0;
			play_q    <= '0;
		end else begin
			esc_q     <= esc_d;
			phase_q   <= phase_d;
			bcnt_q    <= bcnt_d;
			asm_q     <= asm_d;
			len_q     <= len_d;
			wa_q      <= wa_d;
			running_q <= running_d;
			play_q    <= play_d;
		end
	end

endmodule

// ===== rtl/awgcp_out.sv =====
// ----------------------------------------------------------------------------
// awgcp_out
// Result stage and output register; expands the width reply into eight items.
// ----------------------------------------------------------------------------
`include "awg_command_player_assert.svh"

module awgcp_out (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  awgcp_pkg::res_req_t               req,
	input  logic [awgcp_pkg::WAVE_BITS-1:0]   rd_data,
	output logic                              ready,
	awgcp_res_if.source                       res
);

	localparam int BW = awgcp_pkg::BEAT_W;

	logic                 valid_s1;
	awgcp_pkg::op_t       op_s1;
	logic                 status_s1;
	logic [BW-1:0]        beat_q;
	logic                 out_valid_q;
	logic                 kind_q;
	logic [7:0]           reply_q;
	logic [awgcp_pkg::SAMPLE_W-1:0] sample_q;
	logic                 last_q;
	logic                 out_free, widths_last, emit, s1_done;
	logic [7:0]           reply_d;

	assign out_free    = !out_valid_q || res.ready;
	assign widths_last = (beat_q == BW'(awgcp_pkg::BEATS - 1));
	assign emit        = valid_s1 && out_free;
	assign s1_done     = emit && (op_s1 != awgcp_pkg::OP_WIDTHS || widths_last);
	assign ready       = !valid_s1 || s1_done;

	always_comb begin
		case (op_s1)
			awgcp_pkg::OP_STATUS: reply_d = {7'd0, status_s1};
			awgcp_pkg::OP_WIDTHS: reply_d = awgcp_pkg::width_reply_byte(beat_q);
			default:              reply_d = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			beat_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= req.valid;
			end else if (s1_done) begin
				valid_s1 <= 1'b0;
			end
			if (emit && op_s1 == awgcp_pkg::OP_WIDTHS) begin
				beat_q <= widths_last ? '0 : beat_q + 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && req.valid) begin
			op_s1     <= req.op;
			status_s1 <= req.status;
		end
		if (emit) begin
			kind_q   <= (op_s1 == awgcp_pkg::OP_SAMPLE);
			reply_q  <= reply_d;
			sample_q <= (op_s1 == awgcp_pkg::OP_SAMPLE) ?
			            awgcp_pkg::SAMPLE_W'($signed(rd_data)) : '0;
			last_q   <= (op_s1 != awgcp_pkg::OP_WIDTHS) || widths_last;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.result_kind = kind_q;
	assign res.reply_byte  = reply_q;
	assign res.sample_out  = sample_q;
	assign res.last        = last_q;

	`AWGCP_ASSERT_IMP(a_beat_owner, clk, arst_n, beat_q != '0, valid_s1 && op_s1 == awgcp_pkg::OP_WIDTHS)
	`AWGCP_ASSERT_NXT(a_beat_step, clk, arst_n, emit && op_s1 == awgcp_pkg::OP_WIDTHS && !widths_last, beat_q == $past(beat_q) + 1'b1)
	`AWGCP_ASSERT_IMP(a_sample_last, clk, arst_n, out_valid_q && kind_q, last_q)

endmodule

// ===== tb/awg_command_player_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awg_command_player_tb
// Sends host command bytes and sample ticks into the waveform command player.
// A scoreboard predicts every reply byte and played sample from its own copy
// of the parser, length, pointers and sample memory. Each result item is
// checked in order against the oldest expected result.
// ----------------------------------------------------------------------------
module awg_command_player_tb;

	localparam int WB     = awgcp_pkg::WAVE_BITS;
	localparam int PB     = awgcp_pkg::PTR_BITS;
	localparam int DEPTH  = awgcp_pkg::MEM_DEPTH;
	localparam int DBYTES = awgcp_pkg::DATA_BYTES;
	localparam int ABYTES = awgcp_pkg::ADDR_BYTES;

	// One result item as it leaves the block
	typedef struct {
		logic               result_kind;
		logic [7:0]         reply_byte;
		logic signed [15:0] sample_out;
		logic               last;
	} player_result_t;

	// ------------------------------------------------------------------------
	// Scoreboard: predicts the player and holds the results still awaited
	// ------------------------------------------------------------------------
	class player_board;
		bit                    esc_armed;
		awgcp_pkg::phase_t     parse_state;
		int unsigned           byte_count;
		logic [31:0]           asm_word;
		logic [PB-1:0]         len_m1;
		logic [PB-1:0]         wr_addr;
		logic [PB-1:0]         play_addr;
		bit                    running;
		logic [WB-1:0]         wave_mem [DEPTH];
		bit                    wave_written [DEPTH];
		player_result_t        awaited [$];

		function new();
			esc_armed   = 1'b0;
			parse_state = awgcp_pkg::PH_IDLE;
			byte_count  = 0;
			asm_word    = '0;
			len_m1      = '0;
			wr_addr     = '0;
			play_addr   = '0;
			running     = 1'b0;
			foreach (wave_written[i])
				wave_written[i] = 1'b0;
		endfunction

		function void queue_result(logic k, logic [7:0] rb, logic signed [15:0] smp,
				logic lst);
			player_result_t r;
			r.result_kind = k;
			r.reply_byte  = rb;
			r.sample_out  = smp;
			r.last        = lst;
			awaited.push_back(r);
		endfunction

		// Note one accepted input item and queue the results it causes
		function void accept_item(logic k, logic [7:0] b);
			logic [63:0] widths;
			int unsigned need;
			int          i;
			if (k) begin
				// a tick plays only while running
				if (running) begin
					queue_result(1'b1, 8'h00, 16'($signed(wave_mem[play_addr])), 1'b1);
					play_addr = (play_addr == len_m1) ? '0 : play_addr + 1'b1;
				end
				return;
			end
			if (!esc_armed && b == awgcp_pkg::BYTE_RESET) begin
				parse_state = awgcp_pkg::PH_IDLE;
				byte_count  = 0;
				asm_word    = '0;
				return;
			end
			if (!esc_armed && b == awgcp_pkg::BYTE_ESC) begin
				esc_armed = 1'b1;
				return;
			end
			esc_armed = 1'b0;
			if (parse_state == awgcp_pkg::PH_IDLE) begin
				case (b)
				awgcp_pkg::CMD_START: begin
					running   = 1'b1;
					play_addr = '0;
				end
				awgcp_pkg::CMD_STOP: running = 1'b0;
				awgcp_pkg::CMD_WIDTHS: begin
					widths = {32'(PB), 32'(WB)};
					for (i = 0; i < 8; i++)
						queue_result(1'b0, widths[8*i +: 8], '0, i == 7);
				end
				awgcp_pkg::CMD_LOAD: begin
					parse_state = awgcp_pkg::PH_LOAD;
					byte_count  = 0;
					asm_word    = '0;
					wr_addr     = '0;
				end
				awgcp_pkg::CMD_LENGTH: begin
					parse_state = awgcp_pkg::PH_LENGTH;
					byte_count  = 0;
					asm_word    = '0;
				end
				awgcp_pkg::CMD_STATUS: queue_result(1'b0, {7'd0, running}, '0, 1'b1);
				default: ;
				endcase
				return;
			end
			// data byte of a length or a sample, most significant first
			need     = (parse_state == awgcp_pkg::PH_LENGTH) ? ABYTES : DBYTES;
			asm_word = {asm_word[23:0], b};
			if (byte_count + 1 < need) begin
				byte_count++;
				return;
			end
			byte_count = 0;
			if (parse_state == awgcp_pkg::PH_LENGTH) begin
				len_m1      = asm_word[PB-1:0];
				parse_state = awgcp_pkg::PH_IDLE;
			end else begin
				wave_mem[wr_addr]     = asm_word[WB-1:0];
				wave_written[wr_addr] = 1'b1;
				if (wr_addr == len_m1) begin
					wr_addr     = '0;
					parse_state = awgcp_pkg::PH_IDLE;
				end else begin
					wr_addr = wr_addr + 1'b1;
				end
			end
			asm_word = '0;
		endfunction

		// Compare one result item with the oldest expectation; empty if it matches
		function string check_result(logic k, logic [7:0] rb, logic signed [15:0] smp,
				logic lst);
			player_result_t want;
			if (awaited.size() == 0)
				return $sformatf("unexpected result kind=%0d byte=%02h sample=%0d last=%0d",
					k, rb, smp, lst);
			want = awaited.pop_front();
			if (k !== want.result_kind || rb !== want.reply_byte ||
					smp !== want.sample_out || lst !== want.last)
				return $sformatf({"got kind=%0d byte=%02h sample=%0d last=%0d, ",
					"want kind=%0d byte=%02h sample=%0d last=%0d"},
					k, rb, smp, lst, want.result_kind, want.reply_byte,
					want.sample_out, want.last);
			return "";
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		// A tick must never play an entry that was never loaded
		function bit tick_is_safe();
			return !running || wave_written[play_addr];
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Block, channels and run state
	// ------------------------------------------------------------------------
	logic clk;
	logic arst_n;

	awgcp_cmd_if cmd ();
	awgcp_res_if res ();

	awg_command_player u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.res    (res)
	);

	player_board board;
	int          mismatch_count = 0;
	int          items_sent     = 0;
	int          tx_idle_pct;
	int          rx_idle_pct;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Give up on a hung run
	initial begin
		#5_000_000;
		$display("awg_command_player_tb: FAIL");
		$finish;
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	// Result side: check each accepted result item, then pick the next ready.
	// Values read here are the ones present at the edge, since every driver
	// updates with nonblocking assignments.
	always @(posedge clk) begin
		string verdict;
		if (arst_n && res.valid && res.ready) begin
			verdict = board.check_result(res.result_kind, res.reply_byte,
				res.sample_out, res.last);
			if (verdict != "")
				report_mismatch(verdict);
		end
		res.ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// ------------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------------

	// Hold one item on cmd until it is accepted, after a random idle gap.
	// Valid stays high between back-to-back items; drop it only for a gap.
	task automatic send_item(input logic k, input logic [7:0] b);
		while ($urandom_range(99) < tx_idle_pct) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid      <= 1'b1;
		cmd.kind       <= k;
		cmd.byte_value <= b;
		do
			@(posedge clk);
		while (!cmd.ready);
		board.accept_item(k, b);
		items_sent++;
	endtask

	task automatic send_host(input logic [7:0] b);
		send_item(1'b0, b);
	endtask

	// Data byte: escape the two bytes the parser would otherwise act on
	task automatic send_literal(input logic [7:0] b);
		if (b == awgcp_pkg::BYTE_ESC || b == awgcp_pkg::BYTE_RESET)
			send_host(awgcp_pkg::BYTE_ESC);
		send_host(b);
	endtask

	// Command byte, now and then escaped (decoded all the same in idle)
	task automatic send_command(input logic [7:0] c);
		if ($urandom_range(7) == 0)
			send_host(awgcp_pkg::BYTE_ESC);
		send_host(c);
	endtask

	// Skip any tick that would play a never-loaded entry
	task automatic send_ticks(input int n);
		repeat (n) begin
			if (board.tick_is_safe())
				send_item(1'b1, 8'($urandom));
		end
	endtask

	// Hold off input until every expected result has come out
	task automatic wait_drained();
		cmd.valid <= 1'b0;
		do
			@(posedge clk);
		while (board.pending() != 0);
	endtask

	task automatic set_length(input logic [8*ABYTES-1:0] v);
		int i;
		send_command(awgcp_pkg::CMD_LENGTH);
		for (i = ABYTES - 1; i >= 0; i--)
			send_literal(v[8*i +: 8]);
	endtask

	function automatic logic [8*DBYTES-1:0] pick_sample();
		case ($urandom_range(7))
		0: return 16'h8000;
		1: return 16'h7FFF;
		2: return 16'hFFFF;
		3: return 16'h0000;
		4: return 16'h0001;
		default: return 16'($urandom);
		endcase
	endfunction

	// Load count samples; ticks slip in between bytes to play while loading
	task automatic load_wave(input int count);
		logic [8*DBYTES-1:0] s;
		int i;
		int j;
		send_command(awgcp_pkg::CMD_LOAD);
		for (j = 0; j < count; j++) begin
			s = pick_sample();
			for (i = DBYTES - 1; i >= 0; i--) begin
				send_literal(s[8*i +: 8]);
				if ($urandom_range(11) == 0)
					send_ticks(1);
			end
		end
	endtask

	// Short length, random upper bits that the block must cut away
	function automatic logic [8*ABYTES-1:0] pick_length();
		logic [8*ABYTES-1:0] v;
		v = (8*ABYTES)'($urandom);
		case ($urandom_range(19))
		0: v[PB-1:0] = '0;
		1: v[PB-1:0] = PB'($urandom);
		default: v[PB-1:0] = PB'($urandom_range(15));
		endcase
		return v;
	endfunction

	task automatic run_directed();
		// tick while stopped: no result
		send_item(1'b1, 8'hFF);
		send_host(awgcp_pkg::CMD_STATUS);
		send_host(awgcp_pkg::CMD_WIDTHS);
		// length two, then the two extreme samples
		send_host(awgcp_pkg::CMD_LENGTH);
		send_host(8'h00);
		send_host(8'h01);
		send_host(awgcp_pkg::CMD_LOAD);
		send_host(8'h80);
		send_host(8'h00);
		send_host(8'h7F);
		send_host(8'hFF);
		// play through the wrap
		send_host(awgcp_pkg::CMD_START);
		send_item(1'b1, 8'h00);
		send_item(1'b1, 8'hA5);
		send_item(1'b1, 8'h5A);
		send_host(awgcp_pkg::CMD_STATUS);
		// escaped command in idle still decodes
		send_host(awgcp_pkg::BYTE_ESC);
		send_host(awgcp_pkg::CMD_STATUS);
		// escaped reset byte in idle is just an unknown command
		send_host(awgcp_pkg::BYTE_ESC);
		send_host(awgcp_pkg::BYTE_RESET);
		send_host(8'h33);
		// abort a length halfway; the old length stays
		send_host(awgcp_pkg::CMD_LENGTH);
		send_host(8'hFF);
		send_host(awgcp_pkg::BYTE_RESET);
		send_host(awgcp_pkg::CMD_STOP);
		send_item(1'b1, 8'h00);
	endtask

	// Mostly well-formed command sequences with random content, some noise
	task automatic run_random(input int target);
		int          stop_at;
		int          pick;
		logic [7:0]  b;
		stop_at = items_sent + target;
		while (items_sent < stop_at) begin
			if ($urandom_range(1))
				send_host(awgcp_pkg::BYTE_RESET);
			if ($urandom_range(39) == 0)
				wait_drained();
			pick = $urandom_range(99);
			if (pick < 6) begin
				// noise, then resync twice in case the last byte was an escape
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(3) == 0)
						send_ticks(1);
					else
						send_host(8'($urandom));
				end
				send_host(awgcp_pkg::BYTE_RESET);
				send_host(awgcp_pkg::BYTE_RESET);
			end else if (pick < 12) begin
				// sequence cut short by a parser reset
				send_command($urandom_range(1) ? awgcp_pkg::CMD_LOAD : awgcp_pkg::CMD_LENGTH);
				repeat ($urandom_range(1))
					send_literal(8'($urandom));
				if ($urandom_range(1))
					send_host(awgcp_pkg::BYTE_ESC);
				send_host(awgcp_pkg::BYTE_RESET);
				send_host(awgcp_pkg::BYTE_RESET);
			end else if (pick < 22) begin
				set_length(pick_length());
			end else if (pick < 34) begin
				if (board.len_m1 < 32)
					load_wave(int'(board.len_m1) + 1);
				else
					set_length(pick_length());
			end else if (pick < 42) begin
				send_command(awgcp_pkg::CMD_START);
			end else if (pick < 48) begin
				send_command(awgcp_pkg::CMD_STOP);
			end else if (pick < 54) begin
				send_command(awgcp_pkg::CMD_STATUS);
			end else if (pick < 58) begin
				send_command(awgcp_pkg::CMD_WIDTHS);
			end else if (pick < 62) begin
				do
					b = 8'($urandom);
				while (b == awgcp_pkg::BYTE_ESC || b == awgcp_pkg::BYTE_RESET ||
					(b >= awgcp_pkg::CMD_START && b <= awgcp_pkg::CMD_STATUS));
				send_command(b);
			end else begin
				send_ticks($urandom_range(1, 10));
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		board          = new();
		tx_idle_pct    = 17;
		rx_idle_pct    = 58;
		arst_n         <= 1'b0;
		cmd.valid      <= 1'b0;
		cmd.kind       <= 1'b0;
		cmd.byte_value <= 8'h00;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender idles now and then, receiver stalls often
		run_directed();
		run_random(140);
		wait_drained();

		// swap: sender idles often, receiver rarely
		tx_idle_pct = 58;
		rx_idle_pct = 17;
		run_random(140);
		wait_drained();

		// full speed on both sides
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_length(16'd5);
		run_random(150);

		// drain, then give any stray result time to show up
		wait_drained();
		repeat (16) @(posedge clk);
		if (mismatch_count == 0)
			$display("awg_command_player_tb: PASS");
		else
			$display("awg_command_player_tb: FAIL");
		$finish;
	end

endmodule
